FILE: hdl/fisbk_pkg.sv
`default_nettype none

package fisbk_pkg;

   localparam int CAPACITY = 32;
   localparam int COUNT_WIDTH = $clog2(CAPACITY + 1);
   localparam int TOTAL_WIDTH = 6;

   typedef struct packed {
      logic [4:0]  entity_index;
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [15:0] pos_z;
      logic [31:0] depth_tag;
   } entry_type;

   typedef struct packed {
      logic insert;
      logic shift;
   } cell_ctrl_type;

   typedef enum logic [0:0] {
      ST_LOAD,
      ST_DRAIN
   } state_type;

   function automatic logic [TOTAL_WIDTH-1:0] to_total(input logic [COUNT_WIDTH-1:0] count);
      logic [TOTAL_WIDTH+COUNT_WIDTH-1:0] ext;
      ext = (TOTAL_WIDTH + COUNT_WIDTH)'(count);
      return ext[TOTAL_WIDTH-1:0];
   endfunction

endpackage

`default_nettype wire

FILE: hdl/filtered_insertion_sorter_by_key_core.sv
`default_nettype none

// Sorts the drawable, placed entity records of a frame ascending by pos_y, a new record going
// ahead of stored records with an equal key. While loading, one record is taken every cycle:
// each record is broadcast to a chain of CAPACITY cells, and every cell compares it with its own
// entry and either keeps its entry, takes the record, or takes its lower neighbor's entry, all
// in the same cycle. Records beyond CAPACITY are dropped and flagged in rsp_overflowed. After the
// end-of-frame transaction the chain shifts toward its head one slot per accepted result, so a
// frame of N entries gives N results (an empty frame gives a single result with rsp_out_valid
// low); req_stall stays high during the drain, and the chain is empty again when the last
// result is taken.
module filtered_insertion_sorter_by_key_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [4:0]  req_entity_index,
   input  wire logic [15:0] req_pos_x,
   input  wire logic [15:0] req_pos_y,
   input  wire logic [15:0] req_pos_z,
   input  wire logic [31:0] req_depth_tag,
   input  wire logic        req_is_drawable,
   input  wire logic        req_has_placement,
   input  wire logic        req_end_of_frame,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [4:0]       rsp_out_entity,
   output logic [15:0]      rsp_out_x,
   output logic [15:0]      rsp_out_y,
   output logic [15:0]      rsp_out_z,
   output logic [31:0]      rsp_out_depth,
   output logic             rsp_out_valid,
   output logic             rsp_out_last,
   output logic             rsp_overflowed,
   output logic [5:0]       rsp_entry_total
);

   localparam int CAP = fisbk_pkg::CAPACITY;
   localparam int CW  = fisbk_pkg::COUNT_WIDTH;

   fisbk_pkg::state_type     state_ff;
   fisbk_pkg::state_type     state_in;
   logic [CW-1:0]            count_ff;
   logic [CW-1:0]            count_in;
   logic [CW-1:0]            remain_ff;
   logic [CW-1:0]            remain_in;
   logic                     overflow_ff;
   logic                     overflow_in;

   fisbk_pkg::entry_type     new_entry;
   fisbk_pkg::cell_ctrl_type ctrl;
   fisbk_pkg::entry_type     cell_entry [CAP];
   logic [CAP-1:0]           cell_valid;
   logic [CAP-1:0]           cell_ge;

   logic                     req_accept;
   logic                     rsp_accept;
   logic                     wanted;
   logic                     full;
   logic                     do_insert;
   logic                     head_present;
   logic                     head_last;

   assign new_entry.entity_index = req_entity_index;
   assign new_entry.pos_x        = req_pos_x;
   assign new_entry.pos_y        = req_pos_y;
   assign new_entry.pos_z        = req_pos_z;
   assign new_entry.depth_tag    = req_depth_tag;

   assign req_accept   = req_valid && !req_stall;
   assign rsp_accept   = rsp_valid && !rsp_stall;
   assign wanted       = req_is_drawable && req_has_placement;
   assign full         = (count_ff == CW'(CAP));
   assign do_insert    = req_accept && wanted && !full;
   assign head_present = (remain_ff != '0);
   assign head_last    = (remain_ff <= CW'(1));

   assign ctrl.insert = do_insert;
   assign ctrl.shift  = rsp_accept && head_present;

   for (genvar i = 0; i < CAP; i++) begin : g_cell
      fisbk_pkg::entry_type prev_entry;
      fisbk_pkg::entry_type next_entry;
      logic                 prev_ge;
      logic                 prev_valid;
      logic                 next_valid;

      if (i == 0) begin : g_head
         assign prev_entry = new_entry;
         assign prev_ge    = 1'b0;
         assign prev_valid = 1'b1;
      end else begin : g_body
         assign prev_entry = cell_entry[i-1];
         assign prev_ge    = cell_ge[i-1];
         assign prev_valid = cell_valid[i-1];
      end

      if (i == CAP - 1) begin : g_tail
         assign next_entry = new_entry;
         assign next_valid = 1'b0;
      end else begin : g_mid
         assign next_entry = cell_entry[i+1];
         assign next_valid = cell_valid[i+1];
      end

      fisbk_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .new_entry  (new_entry),
         .prev_entry (prev_entry),
         .prev_ge    (prev_ge),
         .prev_valid (prev_valid),
         .next_entry (next_entry),
         .next_valid (next_valid),
         .entry      (cell_entry[i]),
         .valid      (cell_valid[i]),
         .ge         (cell_ge[i])
      );
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fisbk_pkg::ST_LOAD: begin
            if (req_accept && req_end_of_frame) begin
               state_in = fisbk_pkg::ST_DRAIN;
            end
         end
         fisbk_pkg::ST_DRAIN: begin
            if (rsp_accept && head_last) begin
               state_in = fisbk_pkg::ST_LOAD;
            end
         end
         default: state_in = fisbk_pkg::ST_LOAD;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         fisbk_pkg::ST_LOAD: begin
            req_stall = 1'b0;
            rsp_valid = 1'b0;
         end
         fisbk_pkg::ST_DRAIN: begin
            req_stall = 1'b1;
            rsp_valid = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
            rsp_valid = 1'b0;
         end
      endcase
   end

   always_comb begin
      count_in    = count_ff;
      remain_in   = remain_ff;
      overflow_in = overflow_ff;
      if (do_insert) begin
         count_in = count_ff + CW'(1);
      end
      if (req_accept && wanted && full) begin
         overflow_in = 1'b1;
      end
      if (req_accept && req_end_of_frame) begin
         remain_in = count_in;
      end
      if (rsp_accept) begin
         if (head_last) begin
            count_in    = '0;
            remain_in   = '0;
            overflow_in = 1'b0;
         end else begin
            remain_in = remain_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= fisbk_pkg::ST_LOAD;
         count_ff    <= '0;
         remain_ff   <= '0;
         overflow_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         remain_ff   <= remain_in;
         overflow_ff <= overflow_in;
      end
   end

   assign rsp_out_entity  = head_present ? cell_entry[0].entity_index : '0;
   assign rsp_out_x       = head_present ? cell_entry[0].pos_x : '0;
   assign rsp_out_y       = head_present ? cell_entry[0].pos_y : '0;
   assign rsp_out_z       = head_present ? cell_entry[0].pos_z : '0;
   assign rsp_out_depth   = head_present ? cell_entry[0].depth_tag : '0;
   assign rsp_out_valid   = head_present;
   assign rsp_out_last    = head_last;
   assign rsp_overflowed  = overflow_ff;
   assign rsp_entry_total = head_present ? fisbk_pkg::to_total(count_ff) : '0;

endmodule

`default_nettype wire

FILE: hdl/fisbk_cell.sv
`default_nettype none

module fisbk_cell (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire fisbk_pkg::cell_ctrl_type ctrl,
   input  wire fisbk_pkg::entry_type    new_entry,
   input  wire fisbk_pkg::entry_type    prev_entry,
   input  wire logic                    prev_ge,
   input  wire logic                    prev_valid,
   input  wire fisbk_pkg::entry_type    next_entry,
   input  wire logic                    next_valid,
   output fisbk_pkg::entry_type         entry,
   output logic                         valid,
   output logic                         ge
);

   fisbk_pkg::entry_type entry_ff;
   fisbk_pkg::entry_type entry_in;
   logic                 valid_ff;
   logic                 valid_in;

   assign ge    = valid_ff && (entry_ff.pos_y >= new_entry.pos_y);
   assign entry = entry_ff;
   assign valid = valid_ff;

   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      priority if (ctrl.shift) begin
         entry_in = next_entry;
         valid_in = next_valid;
      end else if (ctrl.insert) begin
         priority if (prev_ge) begin
            entry_in = prev_entry;
            valid_in = 1'b1;
         end else if (ge || (!valid_ff && prev_valid)) begin
            entry_in = new_entry;
            valid_in = 1'b1;
         end else begin
            entry_in = entry_ff;
            valid_in = valid_ff;
         end
      end else begin
         entry_in = entry_ff;
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/fisbk_checker.sv
`default_nettype none

module fisbk_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [15:0] rsp_out_y,
   input wire logic        rsp_out_valid,
   input wire logic        rsp_out_last,
   input wire logic [5:0]  rsp_entry_total
);

   // hold off new transactions while a frame drains
   a_stall_during_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input accepted while results pending");

   a_frame_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_out_last) |=> rsp_valid)
      else $error("frame ended before last result");

   a_sorted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_out_last) |=> (rsp_out_y >= $past(rsp_out_y)))
      else $error("results out of key order");

   a_empty_frame: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_out_valid) |-> (rsp_out_last && (rsp_entry_total == 6'd0)))
      else $error("empty frame result malformed");

endmodule

bind filtered_insertion_sorter_by_key_core fisbk_checker u_fisbk_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_out_y       (rsp_out_y),
   .rsp_out_valid   (rsp_out_valid),
   .rsp_out_last    (rsp_out_last),
   .rsp_entry_total (rsp_entry_total)
);

`default_nettype wire
